FILE: rtl/wcd_pkg.sv
package wcd_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int NUM_COMPONENTS = 6;
  localparam int NUM_PAIRS      = NUM_COMPONENTS / 2;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int WEIGHT_BITS = 8;
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_RESET = 8'd16;  // 1.0 in Q4.4

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WEIGHT_CR            = 1'b0,
    REG_WEIGHT_SECOND_REGION = 1'b1
  } cfg_reg_t;

  // Per-component weights in Q8.8; tau*sigma needs the full 16 bits
  localparam int WEIGHT_W       = 2 * WEIGHT_BITS;
  localparam int WEIGHT_ONE     = 256;
  localparam int WEIGHT_TS_INIT = 256;  // reset sigma times reset tau

  // Datapath widths
  localparam int SQ_W      = 2 * COMPONENT_BITS;
  localparam int PROD_W    = SQ_W + WEIGHT_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int SUM_W     = PROD_W + 3;
  localparam int SUM_SHIFT = 8;
  localparam int SHIFT_W   = SUM_W - SUM_SHIFT;

  localparam int RESULT_BITS = 21;
  localparam int ROOT_IN_W   = 2 * RESULT_BITS;
  localparam int TRIAL_W     = ROOT_IN_W + 1;
  localparam int EXT_W       = (SHIFT_W > ROOT_IN_W) ? SHIFT_W : ROOT_IN_W + 1;
  localparam logic [RESULT_BITS-1:0] RESULT_MAX = {RESULT_BITS{1'b1}};

  // Pipeline: difference, square, weight, pair sum, final sum, then one
  // stage per result bit of the square root.
  localparam int FRONT_STAGES = 5;
  localparam int NUM_STAGES   = FRONT_STAGES + RESULT_BITS;

  typedef logic [COMPONENT_BITS-1:0] comp_t;

endpackage

FILE: rtl/weighted_color_distance.sv
// Weighted color distance between two six-component Q8.8 vectors.
//
// Input channel: in_valid / in_stall, with first_comp0..5 and second_comp0..5.
// Output channel: out_valid / out_stall, with distance, the floor of
// the square root of the weighted squared-difference sum, in units of 1/256.
// Weights are 1, sigma, tau, tau, tau*sigma, tau*sigma; sigma and tau are
// Q4.4 and come in through the write port (cfg_write, cfg_index, cfg_data).
//
// Pipeline: an item enters the first of 26 register stages at its accepting
// edge and out_valid rises once it reaches the last one. Five stages do
// the difference, square, weight multiply and two-level sum, then 21 do the
// square root, which resolves one result bit per stage.
// Throughput is one item per cycle while in_stall is low.
//
// Reset clears every valid bit and sets both weights to 1.0.
// While out_stall is high the held item stays on the output and the stages
// behind it keep moving until they fill up; in_stall rises only when every
// stage holds an item and the output is stalled.
module weighted_color_distance (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [wcd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [wcd_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    first_comp0,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    first_comp1,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    first_comp2,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    first_comp3,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    first_comp4,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    first_comp5,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    second_comp0,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    second_comp1,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    second_comp2,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    second_comp3,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    second_comp4,
  input  logic [wcd_pkg::COMPONENT_BITS-1:0]    second_comp5,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [wcd_pkg::RESULT_BITS-1:0]       distance
);

  localparam int NC = wcd_pkg::NUM_COMPONENTS;
  localparam int NS = wcd_pkg::NUM_STAGES;
  localparam int RB = wcd_pkg::RESULT_BITS;
  localparam int FS = wcd_pkg::FRONT_STAGES;

  // Configuration
  logic [wcd_pkg::WEIGHT_BITS-1:0] sigma;
  logic [wcd_pkg::WEIGHT_BITS-1:0] tau;
  logic [wcd_pkg::WEIGHT_W-1:0]    weight_ts;
  logic [wcd_pkg::WEIGHT_W-1:0]    weight [NC];

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma     <= wcd_pkg::WEIGHT_RESET;
      tau       <= wcd_pkg::WEIGHT_RESET;
      weight_ts <= wcd_pkg::WEIGHT_W'(wcd_pkg::WEIGHT_TS_INIT);
    end else begin
      if (cfg_write) begin
        unique case (wcd_pkg::cfg_reg_t'(cfg_index))
          wcd_pkg::REG_WEIGHT_CR:            sigma <= cfg_data;
          wcd_pkg::REG_WEIGHT_SECOND_REGION: tau   <= cfg_data;
          default: ;
        endcase
      end
      // registered from sigma and tau, so it lags behind a write to either
      weight_ts <= wcd_pkg::WEIGHT_W'(sigma) * wcd_pkg::WEIGHT_W'(tau);
    end
  end

  always_comb begin
    weight[0] = wcd_pkg::WEIGHT_W'(wcd_pkg::WEIGHT_ONE);
    weight[1] = wcd_pkg::WEIGHT_W'({sigma, 4'b0000});
    weight[2] = wcd_pkg::WEIGHT_W'({tau, 4'b0000});
    weight[3] = wcd_pkg::WEIGHT_W'({tau, 4'b0000});
    weight[4] = weight_ts;
    weight[5] = weight_ts;
  end

  // Flow control: a stage loads when out_stall is low, when it is empty or
  // when a later stage has room, so bubbles collapse under an output stall.
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      adv[i] = !out_stall || ((vld & ({NS{1'b1}} << i)) != ({NS{1'b1}} << i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (vld & ~adv) | ({vld[NS-2:0], in_valid} & adv);
    end
  end

  assign in_stall = !adv[0];

  // Stage 0: absolute differences
  wcd_pkg::comp_t comp_a [NC];
  wcd_pkg::comp_t comp_b [NC];
  wcd_pkg::comp_t diff   [NC];

  always_comb begin
    comp_a[0] = first_comp0;  comp_b[0] = second_comp0;
    comp_a[1] = first_comp1;  comp_b[1] = second_comp1;
    comp_a[2] = first_comp2;  comp_b[2] = second_comp2;
    comp_a[3] = first_comp3;  comp_b[3] = second_comp3;
    comp_a[4] = first_comp4;  comp_b[4] = second_comp4;
    comp_a[5] = first_comp5;  comp_b[5] = second_comp5;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int c = 0; c < NC; c++) begin
        diff[c] <= (comp_a[c] >= comp_b[c]) ? comp_a[c] - comp_b[c]
                                            : comp_b[c] - comp_a[c];
      end
    end
  end

  // Stage 1: squares
  logic [wcd_pkg::SQ_W-1:0] sq [NC];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int c = 0; c < NC; c++) begin
        sq[c] <= wcd_pkg::SQ_W'(diff[c]) * wcd_pkg::SQ_W'(diff[c]);
      end
    end
  end

  // Stage 2: weighting
  logic [wcd_pkg::PROD_W-1:0] prod [NC];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int c = 0; c < NC; c++) begin
        prod[c] <= wcd_pkg::PROD_W'(sq[c]) * wcd_pkg::PROD_W'(weight[c]);
      end
    end
  end

  // Stage 3: pair sums
  logic [wcd_pkg::PAIR_W-1:0] pair [wcd_pkg::NUM_PAIRS];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int p = 0; p < wcd_pkg::NUM_PAIRS; p++) begin
        pair[p] <= wcd_pkg::PAIR_W'(prod[2*p]) + wcd_pkg::PAIR_W'(prod[2*p+1]);
      end
    end
  end

  // Stage 4: final sum, drop 8 of its 24 fraction bits, flag root overflow
  logic [wcd_pkg::SUM_W-1:0]     sum_all;
  logic [wcd_pkg::EXT_W-1:0]     sum_ext;
  logic [wcd_pkg::ROOT_IN_W-1:0] radicand;
  logic                          radicand_sat;

  always_comb begin
    sum_all = wcd_pkg::SUM_W'(pair[0]) + wcd_pkg::SUM_W'(pair[1])
            + wcd_pkg::SUM_W'(pair[2]);
    sum_ext = wcd_pkg::EXT_W'(sum_all >> wcd_pkg::SUM_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      radicand     <= sum_ext[wcd_pkg::ROOT_IN_W-1:0];
      radicand_sat <= |(sum_ext >> wcd_pkg::ROOT_IN_W);
    end
  end

  // Square root: stage j decides result bit RB-1-j.
  // rem holds radicand minus root squared.
  logic [wcd_pkg::ROOT_IN_W-1:0] rem      [RB];
  logic [RB-1:0]                 root     [RB];
  logic                          root_sat [RB];
  logic [wcd_pkg::ROOT_IN_W-1:0] rem_src  [RB];
  logic [RB-1:0]                 root_src [RB];
  logic                          sat_src  [RB];

  for (genvar j = 0; j < RB; j++) begin : g_root
    localparam int K = RB - 1 - j;
    logic [wcd_pkg::TRIAL_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_src[j]  = radicand;
      assign root_src[j] = '0;
      assign sat_src[j]  = radicand_sat;
    end else begin : g_next
      assign rem_src[j]  = rem[j-1];
      assign root_src[j] = root[j-1];
      assign sat_src[j]  = root_sat[j-1];
    end

    // (root + 2^K)^2 - root^2
    assign trial = (wcd_pkg::TRIAL_W'(root_src[j]) << (K + 1))
                 | (wcd_pkg::TRIAL_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (adv[FS + j]) begin
        root_sat[j] <= sat_src[j];
        if ({1'b0, rem_src[j]} >= trial) begin
          rem[j]  <= rem_src[j] - trial[wcd_pkg::ROOT_IN_W-1:0];
          root[j] <= root_src[j] | (RB'(1) << K);
        end else begin
          rem[j]  <= rem_src[j];
          root[j] <= root_src[j];
        end
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign distance  = root_sat[RB-1] ? wcd_pkg::RESULT_MAX : root[RB-1];

endmodule

FILE: rtl/wcd_check.sv
module wcd_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [wcd_pkg::RESULT_BITS-1:0] distance
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // input backs up only when the output holds a stalled item
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output item dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(distance))
    else $error("stalled output item changed");

endmodule

bind weighted_color_distance wcd_check u_wcd_check (.*);
